FILE: src/mwo_pkg.sv
`default_nettype none

package mwo_pkg;

   // table geometry defaults
   localparam int WT_FRAME_COUNT   = 8;
   localparam int WT_TABLE_SAMPLES = 256;
   localparam int WT_BANK_COUNT    = 5;
   localparam int WT_MIP_COUNT     = 3;

   // result queue depth, also the number of samples allowed in flight
   localparam int RSP_QUEUE_DEPTH = 4;
   // request queue between front and back
   localparam int JOB_QUEUE_DEPTH = 2;

   // morph position is Q3.12
   localparam int MORPH_FRAC_BITS = 12;

   // mip thresholds: level 0 while inc*48 <= 2^32, level 1 while inc*16 <= 2^32
   localparam logic [32:0] PHASE_ONE  = 33'h1_0000_0000;
   localparam logic [31:0] MIP0_LIMIT = 32'(PHASE_ONE / 48);
   localparam logic [31:0] MIP1_LIMIT = 32'(PHASE_ONE / 16);

   // unity gain in Q1.15
   localparam logic [15:0] LEVEL_UNITY = 16'h8000;
   localparam logic [15:0] LEVEL_RESET = 16'd26214;

   // item kinds
   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   // register map
   localparam int          CSR_ADDR_W      = 4;
   localparam logic [1:0]  REG_BANK_SELECT = 2'd0;
   localparam logic [1:0]  REG_MORPH_BASE  = 2'd1;
   localparam logic [1:0]  REG_OUTPUT_LVL  = 2'd2;

   typedef struct packed {
      logic               func;
      logic [1:0]         table_mip;
      logic [2:0]         table_bank;
      logic [2:0]         table_frame;
      logic [7:0]         table_index;
      logic signed [15:0] table_value;
      logic [31:0]        phase_increment;
      logic signed [15:0] morph_offset;
   } mwo_req_type;

   typedef struct packed {
      logic signed [15:0] sample_out;
      logic [1:0]         mip_used;
   } mwo_rsp_type;

   typedef struct packed {
      logic [2:0]  bank_select;
      logic [14:0] morph_base;
      logic [15:0] output_level;
   } mwo_cfg_type;

   // classified work handed from front to back
   typedef struct packed {
      logic        is_load;
      logic [1:0]  mip;
      logic [2:0]  bank;
      logic [3:0]  frame;
      logic [7:0]  index;
      logic [15:0] value;
      logic [11:0] fmix;
      logic [31:0] phase;
   } mwo_job_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_RD_A0,
      SEQ_RD_A1,
      SEQ_RD_B0,
      SEQ_RD_B1
   } mwo_seq_state_type;

endpackage

`default_nettype wire

FILE: src/mwo_ram.sv
`default_nettype none

module mwo_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire                                       clock,
   input  wire                                       we,
   input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire  [WIDTH-1:0]                          wdata,
   input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rd_ff <= mem_ff[raddr];
   end

   assign rdata = rd_ff;

endmodule

`default_nettype wire

FILE: src/mwo_queue.sv
`default_nettype none

module mwo_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              push,
   input  wire  [WIDTH-1:0] push_data,
   output logic             full,
   input  wire              pop,
   output logic             valid,
   output logic [WIDTH-1:0] head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign valid = (count_ff != '0);
   assign head  = mem_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: src/mwo_front.sv
`default_nettype none

module mwo_front
   import mwo_pkg::*;
#(
   parameter int FRAME_COUNT   = WT_FRAME_COUNT,
   parameter int TABLE_SAMPLES = WT_TABLE_SAMPLES,
   parameter int BANK_COUNT    = WT_BANK_COUNT,
   parameter int MIP_COUNT     = WT_MIP_COUNT
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  mwo_req_type       req_payload,
   input  mwo_cfg_type       cfg,
   output logic              job_push,
   output mwo_job_type       job,
   input  wire               job_full
);

   localparam logic [1:0]  MIP_TOP   = 2'(MIP_COUNT - 1);
   localparam logic [2:0]  BANK_TOP  = 3'(BANK_COUNT - 1);
   localparam int          MORPH_MAX = ((FRAME_COUNT - 1) << MORPH_FRAC_BITS) - 1;

   logic [31:0]        phase_ff, phase_in;
   logic               accept;
   logic               is_sample;
   logic               load_ok;
   logic [1:0]         mip_raw;
   logic [1:0]         mip_sel;
   logic [2:0]         bank_sel;
   logic signed [17:0] morph_sum;
   logic [15:0]        morph_clamped;

   assign req_ready = !job_full;
   assign accept    = req_valid && req_ready;
   assign is_sample = (req_payload.func == FUNC_SAMPLE);

   // a load beyond the table geometry is dropped here
   assign load_ok = (32'(req_payload.table_mip)   < 32'(MIP_COUNT))  &&
                    (32'(req_payload.table_bank)  < 32'(BANK_COUNT)) &&
                    (32'(req_payload.table_frame) < 32'(FRAME_COUNT)) &&
                    (32'(req_payload.table_index) < 32'(TABLE_SAMPLES));

   // mip level from the phase step
   always_comb begin
      if (req_payload.phase_increment <= MIP0_LIMIT) begin
         mip_raw = 2'd0;
      end else if (req_payload.phase_increment <= MIP1_LIMIT) begin
         mip_raw = 2'd1;
      end else begin
         mip_raw = 2'd2;
      end
      mip_sel = (mip_raw > MIP_TOP) ? MIP_TOP : mip_raw;
   end

   // playing bank, held to the last one present
   assign bank_sel = (32'(cfg.bank_select) > 32'(BANK_COUNT - 1)) ? BANK_TOP
                                                                   : cfg.bank_select;

   // morph position, clamped to just under the last frame
   always_comb begin
      morph_sum = $signed({3'b000, cfg.morph_base}) +
                  $signed({{2{req_payload.morph_offset[15]}}, req_payload.morph_offset});
      if (morph_sum < 0) begin
         morph_clamped = '0;
      end else if (morph_sum > $signed(18'(MORPH_MAX))) begin
         morph_clamped = 16'(MORPH_MAX);
      end else begin
         morph_clamped = morph_sum[15:0];
      end
   end

   // build the job beat
   always_comb begin
      job.is_load = !is_sample;
      job.value   = req_payload.table_value;
      job.phase   = phase_ff;
      job.fmix    = morph_clamped[11:0];
      if (is_sample) begin
         job.mip   = mip_sel;
         job.bank  = bank_sel;
         job.frame = morph_clamped[15:12];
         job.index = '0;
      end else begin
         job.mip   = req_payload.table_mip;
         job.bank  = req_payload.table_bank;
         job.frame = {1'b0, req_payload.table_frame};
         job.index = req_payload.table_index;
      end
   end

   assign job_push = accept && (is_sample || load_ok);

   // phase advances once per sample beat
   assign phase_in = (accept && is_sample) ? phase_ff + req_payload.phase_increment
                                           : phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else begin
         phase_ff <= phase_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/mwo_back.sv
`default_nettype none

module mwo_back
   import mwo_pkg::*;
#(
   parameter int FRAME_COUNT   = WT_FRAME_COUNT,
   parameter int TABLE_SAMPLES = WT_TABLE_SAMPLES,
   parameter int BANK_COUNT    = WT_BANK_COUNT,
   parameter int MIP_COUNT     = WT_MIP_COUNT
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          job_valid,
   input  mwo_job_type  job,
   output logic         job_pop,
   input  mwo_cfg_type  cfg,
   output logic         out_push,
   output mwo_rsp_type  out_data,
   input  wire          rsp_taken
);

   localparam int WORDS = MIP_COUNT * BANK_COUNT * FRAME_COUNT * TABLE_SAMPLES;
   localparam int AW    = $clog2(WORDS);
   localparam int SW    = $clog2(TABLE_SAMPLES);
   localparam int POS_W = 33 + SW;
   localparam int CW    = $clog2(RSP_QUEUE_DEPTH + 1);

   localparam logic [AW-1:0] BANKS_AW   = AW'(BANK_COUNT);
   localparam logic [AW-1:0] FRAMES_AW  = AW'(FRAME_COUNT);
   localparam logic [AW-1:0] SAMPLES_AW = AW'(TABLE_SAMPLES);
   localparam logic [SW-1:0] IDX_LAST   = SW'(TABLE_SAMPLES - 1);

   typedef struct packed {
      logic [AW-1:0] base0;
      logic [SW-1:0] i0;
      logic [SW-1:0] i1;
      logic [15:0]   sf;
      logic [11:0]   fmix;
      logic [1:0]    mip;
   } mwo_cur_type;

   mwo_seq_state_type state_ff, state_in;
   mwo_seq_state_type rd_state_ff;
   logic              rd_vld_ff;
   mwo_cur_type       cur_ff, cur_in;
   logic [CW-1:0]     credit_ff, credit_in;

   logic              start;
   logic              do_load;
   logic              credit_ok;
   logic [AW-1:0]     row_base;
   logic [POS_W-1:0]  pos;
   logic [SW-1:0]     pos_i0;
   logic [AW-1:0]     raddr;
   logic [15:0]       rdata;
   logic [15:0]       rd_off;

   // read-side stage registers
   logic [15:0]        x0_ff, y0_ff, sa_ff;
   logic signed [32:0] prod_a_ff, prod_b_ff;
   logic [15:0]        sf1_ff;
   logic [11:0]        fmix1_ff;
   logic [1:0]         mip1_ff;
   logic signed [16:0] diff_a, diff_b;
   logic signed [32:0] prod_a_in, prod_b_in;

   // tail stage registers
   logic [4:0]         pv_ff, pv_in;
   logic [15:0]        sb_ff, sa2_ff, sa3_ff, v_ff;
   logic [11:0]        fmix2_ff;
   logic [1:0]         mip2_ff, mip3_ff, mip4_ff, mip5_ff;
   logic signed [29:0] prod_f_ff;
   logic signed [16:0] diff_f;
   logic signed [29:0] prod_f_in;
   logic [31:0]        prod_l_ff;
   logic [15:0]        level;
   logic signed [17:0] scaled;

   assign credit_ok = (credit_ff < CW'(RSP_QUEUE_DEPTH));

   // sequencer: loads only while no reads are out, samples back to back
   always_comb begin
      state_in = state_ff;
      start    = 1'b0;
      do_load  = 1'b0;
      if (job_valid && job.is_load) begin
         do_load = (state_ff == SEQ_IDLE);
      end else if (job_valid) begin
         start = ((state_ff == SEQ_IDLE) || (state_ff == SEQ_RD_B1)) && credit_ok;
      end
      case (state_ff)
         SEQ_IDLE:  state_in = start ? SEQ_RD_A0 : SEQ_IDLE;
         SEQ_RD_A0: state_in = SEQ_RD_A1;
         SEQ_RD_A1: state_in = SEQ_RD_B0;
         SEQ_RD_B0: state_in = SEQ_RD_B1;
         SEQ_RD_B1: state_in = start ? SEQ_RD_A0 : SEQ_IDLE;
         default:   state_in = SEQ_IDLE;
      endcase
   end

   assign job_pop   = start || do_load;
   assign credit_in = credit_ff + CW'(start) - CW'(rsp_taken);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= SEQ_IDLE;
         rd_vld_ff <= 1'b0;
         credit_ff <= '0;
         pv_ff     <= '0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= (state_ff != SEQ_IDLE);
         credit_ff <= credit_in;
         pv_ff     <= pv_in;
      end
   end

   // row start of (mip, bank, frame), shared by load writes and sample setup
   assign row_base = ((AW'(job.mip) * BANKS_AW + AW'(job.bank)) * FRAMES_AW
                      + AW'(job.frame)) * SAMPLES_AW;

   // sample setup: table position from the phase
   assign pos    = POS_W'(job.phase) * POS_W'(TABLE_SAMPLES);
   assign pos_i0 = pos[32 +: SW];

   always_comb begin
      cur_in.base0 = row_base;
      cur_in.i0    = pos_i0;
      cur_in.i1    = (pos_i0 == IDX_LAST) ? '0 : pos_i0 + 1'b1;
      cur_in.sf    = pos[31:16];
      cur_in.fmix  = job.fmix;
      cur_in.mip   = job.mip;
   end

   always_ff @(posedge clock) begin
      rd_state_ff <= state_ff;
      if (start) begin
         cur_ff <= cur_in;
      end
   end

   // read address: frame f0 then f0+1, sample i0 then i1
   always_comb begin
      case (state_ff)
         SEQ_RD_A0: raddr = cur_ff.base0 + AW'(cur_ff.i0);
         SEQ_RD_A1: raddr = cur_ff.base0 + AW'(cur_ff.i1);
         SEQ_RD_B0: raddr = cur_ff.base0 + SAMPLES_AW + AW'(cur_ff.i0);
         SEQ_RD_B1: raddr = cur_ff.base0 + SAMPLES_AW + AW'(cur_ff.i1);
         default:   raddr = cur_ff.base0;
      endcase
   end

   mwo_ram #(
      .WIDTH (16),
      .DEPTH (WORDS)
   ) u_ram (
      .clock (clock),
      .we    (do_load),
      .waddr (row_base + AW'(job.index)),
      .wdata (job.value),
      .raddr (raddr),
      .rdata (rdata)
   );

   // table words handled in offset binary
   assign rd_off    = {~rdata[15], rdata[14:0]};
   assign diff_a    = $signed({1'b0, rd_off}) - $signed({1'b0, x0_ff});
   assign diff_b    = $signed({1'b0, rd_off}) - $signed({1'b0, y0_ff});
   assign prod_a_in = diff_a * $signed({1'b0, cur_ff.sf});
   assign prod_b_in = diff_b * $signed({1'b0, sf1_ff});

   // sample-direction interpolation as the words arrive
   always_ff @(posedge clock) begin
      if (rd_vld_ff) begin
         case (rd_state_ff)
            SEQ_RD_A0: begin
               x0_ff    <= rd_off;
               sf1_ff   <= cur_ff.sf;
               fmix1_ff <= cur_ff.fmix;
               mip1_ff  <= cur_ff.mip;
            end
            SEQ_RD_A1: begin
               prod_a_ff <= prod_a_in;
            end
            SEQ_RD_B0: begin
               y0_ff <= rd_off;
               sa_ff <= x0_ff + prod_a_ff[31:16];
            end
            SEQ_RD_B1: begin
               prod_b_ff <= prod_b_in;
            end
            default: begin
            end
         endcase
      end
   end

   // tail stages run every item without stall; credit keeps the result queue from overflow
   assign pv_in     = {pv_ff[3:0], rd_vld_ff && (rd_state_ff == SEQ_RD_B1)};
   assign diff_f    = $signed({1'b0, sb_ff}) - $signed({1'b0, sa2_ff});
   assign prod_f_in = diff_f * $signed({1'b0, fmix2_ff});
   assign level     = (cfg.output_level > LEVEL_UNITY) ? LEVEL_UNITY : cfg.output_level;

   always_ff @(posedge clock) begin
      // second sample lerp
      if (pv_ff[0]) begin
         sb_ff    <= y0_ff + prod_b_ff[31:16];
         sa2_ff   <= sa_ff;
         fmix2_ff <= fmix1_ff;
         mip2_ff  <= mip1_ff;
      end
      // frame-direction product
      if (pv_ff[1]) begin
         prod_f_ff <= prod_f_in;
         sa3_ff    <= sa2_ff;
         mip3_ff   <= mip2_ff;
      end
      // frame lerp
      if (pv_ff[2]) begin
         v_ff    <= sa3_ff + prod_f_ff[27:12];
         mip4_ff <= mip3_ff;
      end
      // gain
      if (pv_ff[3]) begin
         prod_l_ff <= v_ff * level;
         mip5_ff   <= mip4_ff;
      end
   end

   // back to two's complement and saturate
   always_comb begin
      scaled = $signed({1'b0, prod_l_ff[31:15]}) - $signed({2'b00, level});
      if (scaled > 18'sd32767) begin
         out_data.sample_out = 16'sh7FFF;
      end else if (scaled < -18'sd32768) begin
         out_data.sample_out = 16'sh8000;
      end else begin
         out_data.sample_out = scaled[15:0];
      end
      out_data.mip_used = mip5_ff;
   end

   assign out_push = pv_ff[4];

   // samples in flight never exceed the result queue
   assert property (@(posedge clock) disable iff (reset)
      credit_ff <= CW'(RSP_QUEUE_DEPTH))
      else $error("result credit overrun");

   // every pushed result was counted when it started
   assert property (@(posedge clock) disable iff (reset)
      out_push |-> (credit_ff != '0))
      else $error("result pushed without credit");

   // a first read turns into a result a fixed time later
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_RD_A0) |-> ##9 out_push)
      else $error("sample lost in tail pipeline");

endmodule

`default_nettype wire

FILE: src/morphing_wavetable_oscillator.sv
// Sample beat: after four table reads, interpolation and gain, the result is offered
// from the result queue. A new sample starts once the four reads of the previous one
// are issued from the single read port of the table memory, while result credit
// remains. Load beats wait until the reads of an earlier sample are done. At most 6
// samples are in flight: 4 started in the back end or waiting as results, 2 more in
// the job queue. Reset clears the phase accumulator, queues and registers (level to
// 26214); table contents are not cleared and hold nothing valid until written.
`default_nettype none

module morphing_wavetable_oscillator
   import mwo_pkg::*;
#(
   parameter int FRAME_COUNT   = WT_FRAME_COUNT,
   parameter int TABLE_SAMPLES = WT_TABLE_SAMPLES,
   parameter int BANK_COUNT    = WT_BANK_COUNT,
   parameter int MIP_COUNT     = WT_MIP_COUNT
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  mwo_req_type           req_payload,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output mwo_rsp_type           rsp_payload,
   input  wire                   psel,
   input  wire                   penable,
   input  wire                   pwrite,
   input  wire  [CSR_ADDR_W-1:0] paddr,
   input  wire  [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   mwo_cfg_type cfg_ff, cfg_in;
   logic        csr_write;
   logic [1:0]  csr_index;

   logic        job_push;
   logic        job_full;
   mwo_job_type job_in_data;
   logic        job_valid;
   logic        job_pop;
   mwo_job_type job_head;

   logic        out_push;
   mwo_rsp_type out_data;
   logic        out_full;
   logic        rsp_taken;

   // register port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[CSR_ADDR_W-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            REG_BANK_SELECT: cfg_in.bank_select  = pwdata[2:0];
            REG_MORPH_BASE:  cfg_in.morph_base   = pwdata[14:0];
            REG_OUTPUT_LVL:  cfg_in.output_level = pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_BANK_SELECT: prdata = {29'd0, cfg_ff.bank_select};
         REG_MORPH_BASE:  prdata = {17'd0, cfg_ff.morph_base};
         REG_OUTPUT_LVL:  prdata = {16'd0, cfg_ff.output_level};
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bank_select  <= '0;
         cfg_ff.morph_base   <= '0;
         cfg_ff.output_level <= LEVEL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: accept, classify, phase
   mwo_front #(
      .FRAME_COUNT   (FRAME_COUNT),
      .TABLE_SAMPLES (TABLE_SAMPLES),
      .BANK_COUNT    (BANK_COUNT),
      .MIP_COUNT     (MIP_COUNT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .cfg         (cfg_ff),
      .job_push    (job_push),
      .job         (job_in_data),
      .job_full    (job_full)
   );

   // job queue between front and back
   mwo_queue #(
      .WIDTH ($bits(mwo_job_type)),
      .DEPTH (JOB_QUEUE_DEPTH)
   ) u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in_data),
      .full      (job_full),
      .pop       (job_pop),
      .valid     (job_valid),
      .head      (job_head)
   );

   // back: table access and arithmetic
   mwo_back #(
      .FRAME_COUNT   (FRAME_COUNT),
      .TABLE_SAMPLES (TABLE_SAMPLES),
      .BANK_COUNT    (BANK_COUNT),
      .MIP_COUNT     (MIP_COUNT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job       (job_head),
      .job_pop   (job_pop),
      .cfg       (cfg_ff),
      .out_push  (out_push),
      .out_data  (out_data),
      .rsp_taken (rsp_taken)
   );

   // result queue decouples the output from the tail pipeline
   assign rsp_taken = rsp_valid && rsp_ready;

   mwo_queue #(
      .WIDTH ($bits(mwo_rsp_type)),
      .DEPTH (RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_data),
      .full      (out_full),
      .pop       (rsp_taken),
      .valid     (rsp_valid),
      .head      (rsp_payload)
   );

   // credit in the back end keeps pushes off a full queue
   assert property (@(posedge clock) disable iff (reset)
      out_push |-> (!out_full || rsp_taken))
      else $error("result queue overflow");

endmodule

`default_nettype wire

FILE: test/morphing_wavetable_oscillator_tb.sv
module morphing_wavetable_oscillator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mwo_pkg::*;

   localparam int TABLE_WORDS = WT_MIP_COUNT * WT_BANK_COUNT * WT_FRAME_COUNT * WT_TABLE_SAMPLES;
   localparam int SETTINGS_RUN = 9;
   localparam int BEATS_PER_SETTING = 220;
   localparam int DRAIN_CYCLES = 20;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int HOLD_SETTING = 7;
   // no register sits at this index; writes there must be dropped
   localparam logic [1:0] REG_UNMAPPED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   mwo_req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   mwo_rsp_type rsp_payload;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   // oscillator prediction state
   mwo_cfg_type osc_cfg = '{bank_select: 3'd0, morph_base: 15'd0, output_level: LEVEL_RESET};
   logic [31:0] osc_phase = '0;
   logic signed [15:0] table_model [TABLE_WORDS];
   mwo_rsp_type predicted_samples [$];

   // stimulus planning state
   mwo_req_type beats_to_send [$];
   bit table_written [TABLE_WORDS];
   logic [31:0] plan_phase = '0;

   int send_idle_pct = 13;
   int recv_idle_pct = 72;
   bit rsp_hold = 1'b0;
   bit req_fire = 1'b0;
   event long_hold_go;

   int planned_beats = 0;
   int load_beats = 0;
   int sample_beats = 0;
   int samples_checked = 0;
   int error_count = 0;
   int mip_hits [3] = '{0, 0, 0};

   morphing_wavetable_oscillator DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string what);
      error_count++;
      $display("MISMATCH at %0t: %s", $time, what);
   endtask

   function automatic int table_word(input int mip, input int bank, input int frame,
                                     input int idx);
      return ((mip * WT_BANK_COUNT + bank) * WT_FRAME_COUNT + frame) * WT_TABLE_SAMPLES + idx;
   endfunction

   // faster steps play from the smoother mip levels
   function automatic logic [1:0] pick_mip(input logic [31:0] inc);
      logic [63:0] wide;
      int lvl;
      wide = {32'b0, inc};
      if (wide * 48 <= 64'h1_0000_0000) lvl = 0;
      else if (wide * 16 <= 64'h1_0000_0000) lvl = 1;
      else lvl = 2;
      if (lvl > WT_MIP_COUNT - 1) lvl = WT_MIP_COUNT - 1;
      return 2'(lvl);
   endfunction

   function automatic int played_bank();
      if (osc_cfg.bank_select >= WT_BANK_COUNT) return WT_BANK_COUNT - 1;
      return int'(osc_cfg.bank_select);
   endfunction

   // base plus offset, held below the last frame so frame+1 always exists
   function automatic int morph_position(input logic signed [15:0] offset);
      int m;
      int top;
      top = ((WT_FRAME_COUNT - 1) << MORPH_FRAC_BITS) - 1;
      m = int'(osc_cfg.morph_base) + int'(offset);
      if (m < 0) m = 0;
      if (m > top) m = top;
      return m;
   endfunction

   // floor(a + (b-a)*frac/2^bits)
   function automatic int blend(input int a, input int b, input longint frac, input int bits);
      longint span;
      span = longint'(b - a) * frac;
      return a + int'(span >>> bits);
   endfunction

   function automatic mwo_req_type random_beat();
      logic [95:0] raw;
      raw = {$urandom, $urandom, $urandom};
      return raw[$bits(mwo_req_type)-1:0];
   endfunction

   // one accepted request beat: table write or one predicted sample
   task automatic oscillator_step(input mwo_req_type beat);
      int mip, bank, m, f0, fmix, i0, i1, a0, a1, b0, b1, sa, sb, v, lvl, y;
      logic [63:0] pos;
      logic [15:0] sfrac;
      mwo_rsp_type want;
      if (beat.func == FUNC_LOAD) begin
         if (beat.table_mip < WT_MIP_COUNT && beat.table_bank < WT_BANK_COUNT &&
             beat.table_frame < WT_FRAME_COUNT && beat.table_index < WT_TABLE_SAMPLES) begin
            table_model[table_word(beat.table_mip, beat.table_bank, beat.table_frame,
                                   beat.table_index)] = beat.table_value;
         end
         load_beats++;
      end else begin
         mip = pick_mip(beat.phase_increment);
         bank = played_bank();
         m = morph_position(beat.morph_offset);
         f0 = m >> MORPH_FRAC_BITS;
         fmix = m & ((1 << MORPH_FRAC_BITS) - 1);
         pos = {32'b0, osc_phase} * WT_TABLE_SAMPLES;
         i0 = int'(pos >> 32);
         i1 = (i0 + 1) % WT_TABLE_SAMPLES;
         sfrac = pos[31:16];
         a0 = table_model[table_word(mip, bank, f0, i0)];
         a1 = table_model[table_word(mip, bank, f0, i1)];
         b0 = table_model[table_word(mip, bank, f0 + 1, i0)];
         b1 = table_model[table_word(mip, bank, f0 + 1, i1)];
         sa = blend(a0, a1, sfrac, 16);
         sb = blend(b0, b1, sfrac, 16);
         v = blend(sa, sb, fmix, MORPH_FRAC_BITS);
         lvl = (osc_cfg.output_level > LEVEL_UNITY) ? int'(LEVEL_UNITY)
                                                    : int'(osc_cfg.output_level);
         y = int'((longint'(v) * lvl) >>> 15);
         if (y > 32767) y = 32767;
         if (y < -32768) y = -32768;
         want.sample_out = 16'(y);
         want.mip_used = 2'(mip);
         predicted_samples.push_back(want);
         mip_hits[mip]++;
         osc_phase = osc_phase + beat.phase_increment;
         sample_beats++;
      end
   endtask

   task automatic plan_load(input int mip, input int bank, input int frame, input int idx,
                            input logic [15:0] value);
      mwo_req_type beat;
      beat = random_beat();
      beat.func = FUNC_LOAD;
      beat.table_mip = 2'(mip);
      beat.table_bank = 3'(bank);
      beat.table_frame = 3'(frame);
      beat.table_index = 8'(idx);
      beat.table_value = value;
      beats_to_send.push_back(beat);
      if (mip < WT_MIP_COUNT && bank < WT_BANK_COUNT && frame < WT_FRAME_COUNT &&
          idx < WT_TABLE_SAMPLES) begin
         table_written[table_word(mip, bank, frame, idx)] = 1'b1;
         planned_beats++;
      end
   endtask

   // a sample beat, preceded by writes of any table word it would read unwritten
   task automatic plan_sample(input logic [31:0] inc, input logic signed [15:0] offset);
      mwo_req_type beat;
      int mip, bank, f0, i0;
      logic [63:0] pos;
      mip = pick_mip(inc);
      bank = played_bank();
      f0 = morph_position(offset) >> MORPH_FRAC_BITS;
      pos = {32'b0, plan_phase} * WT_TABLE_SAMPLES;
      i0 = int'(pos >> 32);
      for (int k = 0; k < 4; k++) begin
         int frame, idx;
         frame = f0 + k / 2;
         idx = (k % 2 == 0) ? i0 : (i0 + 1) % WT_TABLE_SAMPLES;
         if (!table_written[table_word(mip, bank, frame, idx)])
            plan_load(mip, bank, frame, idx, 16'($urandom));
      end
      beat = random_beat();
      beat.func = FUNC_SAMPLE;
      beat.phase_increment = inc;
      beat.morph_offset = offset;
      beats_to_send.push_back(beat);
      plan_phase = plan_phase + inc;
      planned_beats++;
   endtask

   // config port: setup then access; reads compare prdata with the model
   task automatic csr_access(input logic [1:0] regsel, input bit is_write,
                             input logic [31:0] data);
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = is_write;
      paddr = {regsel, 2'b00};
      pwdata = data;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (is_write) begin
         case (regsel)
            REG_BANK_SELECT: osc_cfg.bank_select = data[2:0];
            REG_MORPH_BASE:  osc_cfg.morph_base = data[14:0];
            REG_OUTPUT_LVL:  osc_cfg.output_level = data[15:0];
            default: ;
         endcase
      end else if (prdata !== data) begin
         report_mismatch($sformatf("register %0d reads %0h, model holds %0h",
                                   regsel, prdata, data));
      end
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   task automatic wait_for_drain();
      do begin
         @(posedge clock);
         #1;
      end while (beats_to_send.size() != 0 || req_valid || predicted_samples.size() != 0);
      // table writes have no result, so give the pipeline time to retire them
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // request driver: next beat goes out once the current one is taken
   always @(negedge clock) begin
      if (!req_valid || req_fire) begin
         if (!reset && beats_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_payload <= beats_to_send.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // request side: accepted beats feed the predictor
   always @(posedge clock) begin
      req_fire <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready) oscillator_step(req_payload);
   end

   // result receiver
   always @(negedge clock) begin
      rsp_ready <= !rsp_hold && ($urandom_range(99) >= recv_idle_pct);
   end

   // long result stall, counted here while the sender keeps offering beats
   initial forever begin
      @(long_hold_go);
      rsp_hold = 1'b1;
      repeat (LONG_HOLD_CYCLES) @(posedge clock);
      rsp_hold = 1'b0;
   end

   // result monitor: each beat against the oldest prediction
   always @(posedge clock) begin
      mwo_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_samples.size() == 0) begin
            report_mismatch($sformatf("sample beat %0h with nothing predicted", rsp_payload));
         end else begin
            want = predicted_samples.pop_front();
            if (rsp_payload.sample_out !== want.sample_out)
               report_mismatch($sformatf("sample %0d: sample_out %0d, predicted %0d",
                                         samples_checked, rsp_payload.sample_out,
                                         want.sample_out));
            if (rsp_payload.mip_used !== want.mip_used)
               report_mismatch($sformatf("sample %0d: mip_used %0d, predicted %0d",
                                         samples_checked, rsp_payload.mip_used,
                                         want.mip_used));
         end
         samples_checked++;
      end
   end

   // run limit
   initial begin
      #10ms;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      int target;
      int bank_val, base_val, level_val;
      logic [31:0] inc;
      logic signed [15:0] offset;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset values of the registers
      csr_access(REG_BANK_SELECT, 1'b0, 32'(osc_cfg.bank_select));
      csr_access(REG_MORPH_BASE, 1'b0, 32'(osc_cfg.morph_base));
      csr_access(REG_OUTPUT_LVL, 1'b0, 32'(osc_cfg.output_level));

      // directed: full-scale words under the first reads, dropped writes
      plan_load(0, 0, 0, 0, 16'sh8000);
      plan_load(0, 0, 0, 1, 16'sh7FFF);
      plan_load(0, 0, 1, 0, 16'sh7FFF);
      plan_load(0, 0, 1, 1, 16'sh8000);
      plan_load(3, 0, 0, 0, 16'h1234);
      plan_load(0, 7, 7, 255, 16'h5A5A);
      plan_load(2, 4, 7, 255, 16'sh7FFF);
      // mip thresholds on both sides, morph clamps, index wrap, phase wrap
      plan_sample(32'd0, 16'sd0);
      plan_sample(MIP0_LIMIT, 16'sd0);
      plan_sample(MIP0_LIMIT + 32'd1, -16'sd32768);
      plan_sample(MIP1_LIMIT, 16'sd32767);
      plan_sample(MIP1_LIMIT + 32'd1, 16'sd28672);
      plan_sample(32'hFFFF_FFFF, -16'sd28672);
      plan_sample(32'h8000_0000, 16'sd4095);
      plan_sample(32'hFF80_0000 - plan_phase, 16'sd4096);
      plan_sample(32'd0, 16'sd0);
      plan_sample(32'h0100_0000, -16'sd1);

      for (int ph = 0; ph < SETTINGS_RUN; ph++) begin
         wait_for_drain();
         case (ph)
            0: begin bank_val = 4; base_val = 28672; level_val = 32768; end
            1: begin bank_val = 0; base_val = 0; level_val = 0; end
            2: begin bank_val = 7; base_val = 32767; level_val = 65535; end
            3: begin bank_val = 2; base_val = 14336; level_val = 16384; end
            5: begin bank_val = 5; base_val = 4095; level_val = 1; end
            6: begin bank_val = 1; base_val = 20000; level_val = 32767; end
            8: begin bank_val = 3; base_val = 8192; level_val = 26214; end
            default: begin
               bank_val = $urandom_range(7);
               base_val = $urandom_range(32767);
               level_val = $urandom_range(65535);
            end
         endcase
         // upper data bits are random; only the register's own bits count
         csr_access(REG_BANK_SELECT, 1'b1, 32'({$urandom, 3'b0} | 35'(bank_val)));
         csr_access(REG_MORPH_BASE, 1'b1, 32'({$urandom, 15'b0} | 47'(base_val)));
         csr_access(REG_OUTPUT_LVL, 1'b1, 32'({$urandom, 16'b0} | 48'(level_val)));
         if (ph == 0) csr_access(REG_UNMAPPED, 1'b1, $urandom);
         csr_access(REG_BANK_SELECT, 1'b0, 32'(osc_cfg.bank_select));
         csr_access(REG_MORPH_BASE, 1'b0, 32'(osc_cfg.morph_base));
         csr_access(REG_OUTPUT_LVL, 1'b0, 32'(osc_cfg.output_level));

         case (ph / 3)
            0: begin send_idle_pct = 13; recv_idle_pct = 72; end
            1: begin send_idle_pct = 72; recv_idle_pct = 13; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase

         // mostly samples over a filling table, some rewrites, some stray writes
         target = planned_beats + BEATS_PER_SETTING;
         while (planned_beats < target) begin
            case ($urandom_range(19))
               0, 1, 2: plan_load($urandom_range(WT_MIP_COUNT - 1), played_bank(),
                                  $urandom_range(WT_FRAME_COUNT - 1),
                                  $urandom_range(WT_TABLE_SAMPLES - 1), 16'($urandom));
               3, 4: plan_load($urandom_range(3), $urandom_range(7), $urandom_range(7),
                               $urandom_range(255), 16'($urandom));
               default: begin
                  case ($urandom_range(2))
                     0: inc = $urandom_range(MIP0_LIMIT);
                     1: inc = $urandom_range(MIP1_LIMIT, MIP0_LIMIT);
                     default: inc = $urandom;
                  endcase
                  if ($urandom_range(3) == 0) offset = 16'($urandom);
                  else offset = 16'(int'($urandom_range(57344)) - 28672);
                  plan_sample(inc, offset);
               end
            endcase
         end
         if (ph == HOLD_SETTING) -> long_hold_go;
      end

      wait_for_drain();
      $display("Checked %0d samples from %0d request beats (%0d table writes) over %0d settings.",
               samples_checked, load_beats + sample_beats, load_beats, SETTINGS_RUN + 1);
      $display("Mip levels 0/1/2 played %0d/%0d/%0d times; one long result stall included.",
               mip_hits[0], mip_hits[1], mip_hits[2]);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: morphing_wavetable_oscillator.f
src/mwo_pkg.sv
src/mwo_ram.sv
src/mwo_queue.sv
src/mwo_front.sv
src/mwo_back.sv
src/morphing_wavetable_oscillator.sv
test/morphing_wavetable_oscillator_tb.sv
